// ===== rtl/lcdc_pkg.sv =====
// ============================================================================
// lcdc_pkg: shared types and constants of the character LCD bus controller
// Item structs for the request and result channels, request codes and the
// power-on sequence table.
// ============================================================================
`default_nettype none

package lcdc_pkg;

  // Request item: one tick, optionally carrying a request.
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic       busy_flag;
  } req_t;

  // Result item: LCD pin levels and status for one tick.
  typedef struct packed {
    logic [7:0] bus_data;
    logic       bus_drive;
    logic       reg_select;
    logic       read_write;
    logic       enable_pin;
    logic       ready_res;
    logic       rejected;
  } rsp_t;

  // Request codes carried in func.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_INIT   = 3'd1;
  localparam logic [2:0] FUNC_CMD    = 3'd2;
  localparam logic [2:0] FUNC_DATA   = 3'd3;
  localparam logic [2:0] FUNC_CURSOR = 3'd4;

  // Reset value of the tick rate register.
  localparam logic [15:0] TICKS_PER_MS_RESET = 16'd1000;

  // Fixed bytes of the protocol.
  localparam logic [7:0] WAKE_BYTE    = 8'h30;
  localparam logic [7:0] CURSOR_BASE  = 8'h80;
  localparam logic [7:0] LINE1_OFFSET = 8'h40;

  // Power-on sequence: number of steps and kinds of step.
  localparam logic [3:0] SEQ_DONE = 4'd12;

  localparam logic [1:0] STEP_DELAY = 2'd0;
  localparam logic [1:0] STEP_WAKE  = 2'd1;
  localparam logic [1:0] STEP_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] arg;
  } step_t;

  // Power-on sequence table: delays in ms, wake pulses and setup commands.
  function automatic step_t init_entry(input logic [3:0] idx);
    step_t e;
    case (idx)
      4'd0:    e = '{kind: STEP_DELAY, arg: 8'd45};
      4'd1:    e = '{kind: STEP_WAKE,  arg: 8'h00};
      4'd2:    e = '{kind: STEP_DELAY, arg: 8'd5};
      4'd3:    e = '{kind: STEP_WAKE,  arg: 8'h00};
      4'd4:    e = '{kind: STEP_DELAY, arg: 8'd1};
      4'd5:    e = '{kind: STEP_WAKE,  arg: 8'h00};
      4'd6:    e = '{kind: STEP_DELAY, arg: 8'd1};
      4'd7:    e = '{kind: STEP_WRITE, arg: 8'h38};
      4'd8:    e = '{kind: STEP_WRITE, arg: 8'h0C};
      4'd9:    e = '{kind: STEP_WRITE, arg: 8'h06};
      4'd10:   e = '{kind: STEP_WRITE, arg: 8'h01};
      4'd11:   e = '{kind: STEP_WRITE, arg: 8'h02};
      default: e = '{kind: STEP_WRITE, arg: 8'h00};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_bus_controller.sv =====
// ============================================================================
// char_lcd_bus_controller: HD44780-style 8-bit LCD bus sequencer
// Turns a stream of tick items into LCD pin levels: power-on init, command,
// data and cursor writes with EN strobe and busy-flag polling.
// ============================================================================
// Every request item is one timing tick and yields exactly one result item
// holding the LCD pin levels for that tick. The block accepts one item per
// clock cycle and shows its result in the cycle after acceptance; the only
// limit on rate is the result register, which stalls the input while a
// result waits to be taken. Delays are counted in accepted items, with
// ticks_per_ms items making one millisecond (1000 after reset, 0 acts as 1).
// Requests arriving while a sequence runs are dropped and flagged rejected.
`default_nettype none

module char_lcd_bus_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_write,
  input  wire logic [15:0]    cfg_data,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire lcdc_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output lcdc_pkg::rsp_t      rsp
);

  logic           accept;
  lcdc_pkg::rsp_t rsp_next;

  assign accept = req_valid && req_ready;

  // Sequencer state and per-tick logic.
  lcdc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .req       (req),
    .rsp_next  (rsp_next)
  );

  // Result register.
  lcdc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_next  (rsp_next),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // An accepted item always leaves a result in the register.
  a_accept_gives_result: assert property (
    @(posedge clk) disable iff (rst) accept |=> rsp_valid
  ) else $error("accepted item left no result");

  // A tick cannot be both accepted as idle and rejected as busy.
  a_ready_or_rejected: assert property (
    @(posedge clk) disable iff (rst)
      rsp_valid |-> !(rsp.ready_res && rsp.rejected)
  ) else $error("result both ready and rejected");

  // A released bus is always a busy poll: instruction read with EN high.
  a_poll_pins: assert property (
    @(posedge clk) disable iff (rst)
      (rsp_valid && !rsp.bus_drive) |->
        (rsp.read_write && rsp.enable_pin && !rsp.reg_select &&
         rsp.bus_data == 8'h00)
  ) else $error("released bus without poll pin levels");

  // A driven bus never reads.
  a_drive_writes: assert property (
    @(posedge clk) disable iff (rst)
      (rsp_valid && rsp.bus_drive) |-> !rsp.read_write
  ) else $error("driven bus with RW high");

endmodule

`default_nettype wire

// ===== rtl/lcdc_seq.sv =====
// ============================================================================
// lcdc_seq: sequencer state and per-tick update
// Holds the sequencer state and the tick rate register, and computes the
// pin levels and status of the current tick together with the next state.
// ============================================================================
`default_nettype none

module lcdc_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          advance,
  input  wire lcdc_pkg::req_t req,
  output lcdc_pkg::rsp_t     rsp_next
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DELAY  = 3'd1;
  localparam logic [2:0] PH_WAKE   = 3'd2;
  localparam logic [2:0] PH_STROBE = 3'd3;
  localparam logic [2:0] PH_POLL   = 3'd4;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  init_step;
    logic [5:0]  ms_left;
    logic [15:0] tick_in_ms;
    logic [7:0]  pending_byte;
    logic        pending_rs;
  } seq_state_t;

  // Starts a byte write: EN high for one millisecond.
  function automatic seq_state_t begin_write(input seq_state_t s_in,
                                             input logic [7:0] b,
                                             input logic rs);
    seq_state_t s;
    s = s_in;
    s.pending_byte = b;
    s.pending_rs   = rs;
    s.phase        = PH_STROBE;
    s.ms_left      = 6'd1;
    s.tick_in_ms   = '0;
    return s;
  endfunction

  // Starts the power-on step that init_step points at, or returns to idle.
  function automatic seq_state_t start_step(input seq_state_t s_in);
    seq_state_t      s;
    lcdc_pkg::step_t e;
    s = s_in;
    e = lcdc_pkg::init_entry(s_in.init_step);
    if (s_in.init_step >= lcdc_pkg::SEQ_DONE) begin
      s.phase = PH_IDLE;
    end else begin
      case (e.kind)
        lcdc_pkg::STEP_DELAY: begin
          s.phase      = PH_DELAY;
          s.ms_left    = e.arg[5:0];
          s.tick_in_ms = '0;
        end
        lcdc_pkg::STEP_WAKE: begin
          s.pending_byte = lcdc_pkg::WAKE_BYTE;
          s.pending_rs   = 1'b0;
          s.phase        = PH_WAKE;
        end
        default: begin
          s = begin_write(s, e.arg, 1'b0);
        end
      endcase
    end
    return s;
  endfunction

  seq_state_t  st;
  seq_state_t  st_next;
  logic [15:0] ticks_per_ms;

  seq_state_t  s;
  logic [15:0] lim;
  logic [15:0] tick_inc;
  logic        ms_wrap;
  logic [5:0]  ms_dec;
  logic [15:0] tick_new;
  logic        count_done;
  logic [7:0]  cursor_cmd;
  logic        ready_res;
  logic        rejected;

  // Cursor command: DDRAM address of the line plus the position.
  assign cursor_cmd = lcdc_pkg::CURSOR_BASE
                    + (req.value[4] ? lcdc_pkg::LINE1_OFFSET : 8'h00)
                    + {4'h0, req.value[3:0]};

  // Request acceptance, pin levels and next state for this tick.
  always_comb begin
    s         = st;
    ready_res = 1'b0;
    rejected  = 1'b0;
    if (s.phase > PH_POLL) begin
      s.phase = PH_IDLE;
    end

    // A request is taken only when idle; the accepting tick starts the action.
    if (s.phase == PH_IDLE) begin
      ready_res = 1'b1;
      case (req.func)
        lcdc_pkg::FUNC_INIT: begin
          s.pending_byte = '0;
          s.pending_rs   = 1'b0;
          s.init_step    = '0;
          s              = start_step(s);
        end
        lcdc_pkg::FUNC_CMD: begin
          s.init_step = lcdc_pkg::SEQ_DONE;
          s           = begin_write(s, req.value, 1'b0);
        end
        lcdc_pkg::FUNC_DATA: begin
          s.init_step = lcdc_pkg::SEQ_DONE;
          s           = begin_write(s, req.value, 1'b1);
        end
        lcdc_pkg::FUNC_CURSOR: begin
          s.init_step = lcdc_pkg::SEQ_DONE;
          s           = begin_write(s, cursor_cmd, 1'b0);
        end
        default: begin
        end
      endcase
    end else begin
      rejected = req.func inside {lcdc_pkg::FUNC_INIT, lcdc_pkg::FUNC_CMD,
                                  lcdc_pkg::FUNC_DATA, lcdc_pkg::FUNC_CURSOR};
    end

    // Pin levels of the phase in force for this tick.
    rsp_next.bus_data   = s.pending_byte;
    rsp_next.bus_drive  = 1'b1;
    rsp_next.reg_select = s.pending_rs;
    rsp_next.read_write = 1'b0;
    rsp_next.enable_pin = 1'b0;
    rsp_next.ready_res  = ready_res;
    rsp_next.rejected   = rejected;
    if (s.phase == PH_WAKE || s.phase == PH_STROBE) begin
      rsp_next.enable_pin = 1'b1;
    end else if (s.phase == PH_POLL) begin
      rsp_next.bus_data   = '0;
      rsp_next.bus_drive  = 1'b0;
      rsp_next.reg_select = 1'b0;
      rsp_next.read_write = 1'b1;
      rsp_next.enable_pin = 1'b1;
    end

    // Millisecond counter; a rate of zero counts as one.
    lim        = (ticks_per_ms == 16'd0) ? 16'd1 : ticks_per_ms;
    tick_inc   = s.tick_in_ms + 16'd1;
    ms_wrap    = (tick_inc >= lim);
    ms_dec     = s.ms_left;
    if (ms_wrap && s.ms_left != 6'd0) begin
      ms_dec = s.ms_left - 6'd1;
    end
    tick_new   = ms_wrap ? 16'd0 : tick_inc;
    count_done = (ms_dec == 6'd0);

    // Phase progress at the end of the tick.
    unique case (s.phase)
      PH_DELAY: begin
        s.tick_in_ms = tick_new;
        s.ms_left    = ms_dec;
        if (count_done) begin
          s.init_step = s.init_step + 4'd1;
          s           = start_step(s);
        end
      end
      PH_WAKE: begin
        s.init_step = s.init_step + 4'd1;
        s           = start_step(s);
      end
      PH_STROBE: begin
        s.tick_in_ms = tick_new;
        s.ms_left    = ms_dec;
        if (count_done) begin
          s.phase = PH_POLL;
        end
      end
      PH_POLL: begin
        if (!req.busy_flag) begin
          if (s.init_step < lcdc_pkg::SEQ_DONE) begin
            s.init_step = s.init_step + 4'd1;
          end
          s = start_step(s);
        end
      end
      default: begin
      end
    endcase
    st_next = s;
  end

  // Sequencer state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, init_step: '0, ms_left: '0, tick_in_ms: '0,
              pending_byte: '0, pending_rs: 1'b0};
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Tick rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= lcdc_pkg::TICKS_PER_MS_RESET;
    end else if (cfg_write) begin
      ticks_per_ms <= cfg_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcdc_out_reg.sv =====
// ============================================================================
// lcdc_out_reg: result register
// Holds one result item until the consumer takes it and gives the input
// side ready whenever the register is empty or being emptied.
// ============================================================================
`default_nettype none

module lcdc_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire lcdc_pkg::rsp_t rsp_next,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output lcdc_pkg::rsp_t      rsp
);

  logic load;

  // A new item may enter as the held one leaves.
  assign req_ready = !rsp_valid || rsp_ready;
  assign load      = req_valid && req_ready;

  // Valid flag of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
